// File: src/grid_dda_wall_column_caster_core_defines.svh
// Assertion macros for the grid DDA wall column caster.
// Used by the top level; no other dependency.
`ifndef GRID_DDA_WALL_COLUMN_CASTER_CORE_DEFINES_SVH
`define GRID_DDA_WALL_COLUMN_CASTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define GDC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GDC_ASSERT_CR(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`else
`define GDC_ASSERT(name, prop, msg)
`define GDC_ASSERT_CR(name, clk, rstn, prop, msg)
`endif
`endif

// File: src/gdc_pkg.sv
// Shared constants, types and helpers of the grid DDA wall column caster.
// No dependencies.
`timescale 1ns / 1ps
package gdc_pkg;

  localparam int unsigned SCREEN_W = 320;
  localparam int unsigned SCREEN_H = 240;
  localparam int unsigned GRID_W   = 32;
  localparam int unsigned GRID_H   = 32;
  localparam int unsigned TEX_W    = 64;
  localparam int unsigned TEX_H    = 64;

  localparam int unsigned CELLS    = GRID_W * GRID_H;
  localparam int unsigned ADDR_W   = $clog2(CELLS);
  localparam int unsigned WALK_MAX = GRID_W + GRID_H + 2;
  localparam int unsigned WALK_W   = $clog2(WALK_MAX + 1);

  localparam int unsigned POS_W    = 22;
  localparam int unsigned VEC_W    = 19;
  localparam int unsigned CAM_W    = 12;
  localparam int unsigned PROD_W   = VEC_W + CAM_W;
  localparam int unsigned RAY_W    = 27;
  localparam int unsigned NUM_W    = 33;
  localparam int unsigned DEN_W    = 48;
  localparam int unsigned DELTA_W  = 41;
  localparam int unsigned SIDE_W   = 48;
  localparam int unsigned COORD_W  = 10;
  localparam int unsigned LH_W     = 24;
  localparam int unsigned STEPR_W  = 25;
  localparam int unsigned NT_W     = 26;
  localparam int unsigned TP_W     = (NT_W - 1) + STEPR_W;

  // SCREEN_W = 64 * 5: shift out the 64, then multiply by a reciprocal of 5
  localparam int unsigned    RAY_PRE_SH = 6;
  localparam int unsigned    RB_W       = 22;
  localparam int unsigned    RCP_SH     = 24;
  localparam logic [RB_W-1:0] RCP5      = 22'd3355444;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 22;

  localparam logic [DELTA_W-1:0] DELTA_INF = DELTA_W'(1) << 40;
  localparam logic [LH_W-1:0]    LH_MAX    = {LH_W{1'b1}};
  localparam logic [22:0]        SAT23     = 23'h7FFFFF;
  localparam logic [23:0]        SAT24     = 24'hFFFFFF;

  localparam logic [POS_W-1:0] RST_POS_X   = 22'd98304;
  localparam logic [POS_W-1:0] RST_POS_Y   = 22'd98304;
  localparam logic [VEC_W-1:0] RST_DIR_X   = 19'h70000;
  localparam logic [VEC_W-1:0] RST_DIR_Y   = 19'h00000;
  localparam logic [VEC_W-1:0] RST_PLANE_X = 19'h00000;
  localparam logic [VEC_W-1:0] RST_PLANE_Y = 19'd43254;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_X   = 3'd0,
    REG_POS_Y   = 3'd1,
    REG_DIR_X   = 3'd2,
    REG_DIR_Y   = 3'd3,
    REG_PLANE_X = 3'd4,
    REG_PLANE_Y = 3'd5
  } gdc_reg_e;

  typedef enum logic [0:0] {
    KIND_WRITE = 1'b0,
    KIND_CAST  = 1'b1
  } gdc_kind_e;

  typedef enum logic [1:0] {
    FACE_WEST  = 2'd0,
    FACE_EAST  = 2'd1,
    FACE_NORTH = 2'd2,
    FACE_SOUTH = 2'd3
  } gdc_face_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RAY_GO,
    S_RAY_DIV,
    S_DELTA_GO,
    S_DELTA_DIV,
    S_SIDE,
    S_WALK,
    S_LOOK,
    S_DIST,
    S_LH_DIV,
    S_SPAN,
    S_STEP_DIV,
    S_TEX,
    S_FIN
  } gdc_state_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } gdc_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quotient;
  } gdc_div_rsp_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } gdc_mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } gdc_mem_rd_t;

  function automatic logic in_map(input logic signed [COORD_W-1:0] x,
                                  input logic signed [COORD_W-1:0] y);
    return !x[COORD_W-1] && (x < COORD_W'(GRID_W)) &&
           !y[COORD_W-1] && (y < COORD_W'(GRID_H));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
    return ADDR_W'(y * GRID_W + x);
  endfunction

endpackage

// File: src/gdc_chan_if.sv
// Handshake channels of the caster: cast/write input, result output, config write.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps
interface gdc_cast_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [4:0]        cell_x;
  logic [4:0]        cell_y;
  logic signed [7:0] cell_value;
  logic [8:0]        column;
  modport source (output valid, kind, cell_x, cell_y, cell_value, column, input ready);
  modport sink   (input valid, kind, cell_x, cell_y, cell_value, column, output ready);
endinterface

interface gdc_res_if;
  logic        valid;
  logic        ready;
  logic [8:0]  out_column;
  logic        wall_hit;
  logic        hit_side;
  logic [1:0]  hit_face;
  logic [7:0]  span_start;
  logic [7:0]  span_end;
  logic [6:0]  wall_texture;
  logic [5:0]  tex_column;
  logic [22:0] tex_row_step;
  logic [22:0] tex_row_start;
  logic        shade;
  logic [23:0] wall_distance;
  modport source (output valid, out_column, wall_hit, hit_side, hit_face, span_start,
                  span_end, wall_texture, tex_column, tex_row_step, tex_row_start,
                  shade, wall_distance, input ready);
  modport sink   (input valid, out_column, wall_hit, hit_side, hit_face, span_start,
                  span_end, wall_texture, tex_column, tex_row_step, tex_row_start,
                  shade, wall_distance, output ready);
endinterface

interface gdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [21:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/gdc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gdc_pkg for widths and request/response structs.
`timescale 1ns / 1ps
module gdc_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gdc_pkg::gdc_div_req_t req_i,
  output gdc_pkg::gdc_div_rsp_t rsp_o
);
  localparam int unsigned CNT_W = $clog2(gdc_pkg::NUM_W + 1);

  logic                      busy_q;
  logic                      done_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [gdc_pkg::NUM_W-1:0] quo_q;
  logic [gdc_pkg::DEN_W-1:0] rem_q, rem_d;
  logic [gdc_pkg::DEN_W-1:0] den_q;
  logic [gdc_pkg::DEN_W:0]   trial;
  logic                      qbit;

  always_comb begin
    trial = {rem_q, quo_q[gdc_pkg::NUM_W-1]};
    qbit  = trial >= {1'b0, den_q};
    rem_d = qbit ? gdc_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[gdc_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(gdc_pkg::NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift the dividend out of the quotient register as quotient bits come in
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[gdc_pkg::NUM_W-2:0], qbit};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

// File: src/gdc_map_mem.sv
// Map cell memory: one write and one registered read port, with a zeroing sweep
// after reset. Depends on gdc_pkg.
`timescale 1ns / 1ps
module gdc_map_mem (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gdc_pkg::gdc_mem_wr_t wr_i,
  input  gdc_pkg::gdc_mem_rd_t rd_i,
  output logic signed [7:0]    rd_data_o,
  output logic                 clr_busy_o
);
  logic [7:0]                 mem_q [gdc_pkg::CELLS];
  logic [7:0]                 rd_data_q;
  logic                       clr_busy_q;
  logic [gdc_pkg::ADDR_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + gdc_pkg::ADDR_W'(1);
      if (clr_addr_q == gdc_pkg::ADDR_W'(gdc_pkg::CELLS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= 8'd0;
    end else if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    // hold read data until the next read
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o  = $signed(rd_data_q);
  assign clr_busy_o = clr_busy_q;
endmodule

// File: src/grid_dda_wall_column_caster_core.sv
// Grid DDA wall column caster: map store, ray setup, DDA walk and wall span math.
// Reset zeroes the map in a sweep over all 1024 cells; no item is taken until it ends.
// A cell write goes into the map as its beat is accepted. A cast runs ray setup,
// up to three divider runs (ray delta, line height, texture step) and a DDA walk
// of at most 66 steps, each a walk state and a map lookup, then registers its result.
// One cast is in flight at a time. Depends on gdc_pkg, gdc_chan_if, gdc_div,
// gdc_map_mem and the defines header.
`timescale 1ns / 1ps
`include "grid_dda_wall_column_caster_core_defines.svh"
module grid_dda_wall_column_caster_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  gdc_cast_if.sink    in_i,
  gdc_res_if.source   res_o,
  gdc_cfg_if.sink     cfg_i
);
  localparam int unsigned RW = gdc_pkg::RAY_W;
  localparam int unsigned SW = gdc_pkg::SIDE_W;
  localparam int unsigned CW = gdc_pkg::COORD_W;
  localparam int unsigned HALF_H = gdc_pkg::SCREEN_H / 2;

  gdc_pkg::gdc_state_e state_q, state_d;

  logic [gdc_pkg::POS_W-1:0]        pos_x_q, pos_y_q;
  logic signed [gdc_pkg::VEC_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

  logic [8:0]                       col_q;
  logic signed [gdc_pkg::CAM_W-1:0] cam_q;
  logic                             negx_q, negy_q;
  logic [gdc_pkg::RB_W-1:0]         bx_q, by_q;
  logic signed [RW-1:0]             rx_q, ry_q;
  logic [gdc_pkg::DELTA_W-1:0]      dx_q, dy_q;
  logic [SW-1:0]                    sx_q, sy_q, dist_q;
  logic signed [CW-1:0]             cx_q, cy_q;
  logic                             side_q, hit_q;
  logic [gdc_pkg::WALK_W-1:0]       walk_n_q;
  logic signed [7:0]                v_q;
  logic [gdc_pkg::LH_W-1:0]         lh_q;
  logic [7:0]                       start_q, end_q;
  logic [gdc_pkg::STEPR_W-1:0]      step_raw_q;
  logic [gdc_pkg::TP_W-1:0]         tprod_q;
  logic                             num_neg_q;
  logic [31:0]                      wprod_q;
  logic                             nb_in_q;

  logic        res_valid_q;
  logic        res_hit_q, res_side_q, res_shade_q;
  logic [8:0]  res_col_q;
  logic [1:0]  res_face_q;
  logic [7:0]  res_start_q, res_end_q;
  logic [6:0]  res_tex_q;
  logic [5:0]  res_tcol_q;
  logic [22:0] res_step_q, res_tstart_q;
  logic [23:0] res_dist_q;

  gdc_pkg::gdc_div_req_t div_x_req, div_y_req;
  gdc_pkg::gdc_div_rsp_t div_x_rsp, div_y_rsp;
  gdc_pkg::gdc_mem_wr_t  wr_req;
  gdc_pkg::gdc_mem_rd_t  rd_req;
  logic signed [7:0]     rd_data;
  logic                  clr_busy;

  logic in_acc, res_free, in_ready;

  // ray setup
  logic signed [gdc_pkg::PROD_W-1:0] prod_x, prod_y;
  logic [gdc_pkg::PROD_W-1:0]        abs_px, abs_py;
  logic [2*gdc_pkg::RB_W-1:0]        rq_x, rq_y;
  logic signed [RW-1:0]              qx_s, qy_s;
  logic                              rx_neg, ry_neg, rx_zero, ry_zero;
  logic [RW-1:0]                     abs_rx, abs_ry;
  logic [16:0]                       fsel_x, fsel_y;
  logic [49:0]                       smul_x, smul_y;
  // walk
  logic                              step_x;
  logic signed [CW-1:0]              cx_n, cy_n, nx, ny;
  logic                              n_in;
  logic [SW-1:0]                     dist_d;
  // span and texture
  logic [gdc_pkg::LH_W-1:0]          half;
  logic                              half_big;
  logic signed [gdc_pkg::NT_W-1:0]   num_t;
  logic signed [RW-1:0]              wsel;
  logic [31:0]                       wop;
  logic [63:0]                       wfull;
  logic [15:0]                       wfrac;
  logic [21:0]                       tmul;
  logic [5:0]                        tcol;
  logic                              mirror;
  logic [gdc_pkg::TP_W-1:0]          thalf;
  logic [22:0]                       tstart, step_sat;
  logic [1:0]                        face;
  logic [6:0]                        vm1;

  assign in_acc   = in_i.valid && in_ready;
  assign res_free = !res_valid_q || res_o.ready;

  gdc_div u_div_x (.clk_i, .rst_ni, .req_i(div_x_req), .rsp_o(div_x_rsp));
  gdc_div u_div_y (.clk_i, .rst_ni, .req_i(div_y_req), .rsp_o(div_y_rsp));

  gdc_map_mem u_mem (
    .clk_i, .rst_ni,
    .wr_i      (wr_req),
    .rd_i      (rd_req),
    .rd_data_o (rd_data),
    .clr_busy_o(clr_busy)
  );

  // configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= gdc_pkg::RST_POS_X;
      pos_y_q   <= gdc_pkg::RST_POS_Y;
      dir_x_q   <= gdc_pkg::RST_DIR_X;
      dir_y_q   <= gdc_pkg::RST_DIR_Y;
      plane_x_q <= gdc_pkg::RST_PLANE_X;
      plane_y_q <= gdc_pkg::RST_PLANE_Y;
    end else if (cfg_i.valid) begin
      case (gdc_pkg::gdc_reg_e'(cfg_i.index))
        gdc_pkg::REG_POS_X:   pos_x_q   <= cfg_i.data;
        gdc_pkg::REG_POS_Y:   pos_y_q   <= cfg_i.data;
        gdc_pkg::REG_DIR_X:   dir_x_q   <= cfg_i.data[gdc_pkg::VEC_W-1:0];
        gdc_pkg::REG_DIR_Y:   dir_y_q   <= cfg_i.data[gdc_pkg::VEC_W-1:0];
        gdc_pkg::REG_PLANE_X: plane_x_q <= cfg_i.data[gdc_pkg::VEC_W-1:0];
        gdc_pkg::REG_PLANE_Y: plane_y_q <= cfg_i.data[gdc_pkg::VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath combinational terms
  always_comb begin
    prod_x  = plane_x_q * cam_q;
    prod_y  = plane_y_q * cam_q;
    abs_px  = prod_x[gdc_pkg::PROD_W-1] ? gdc_pkg::PROD_W'(-prod_x)
                                        : gdc_pkg::PROD_W'(prod_x);
    abs_py  = prod_y[gdc_pkg::PROD_W-1] ? gdc_pkg::PROD_W'(-prod_y)
                                        : gdc_pkg::PROD_W'(prod_y);
    // divide by 5 with a reciprocal; exact for the pre-shifted magnitude range
    rq_x    = bx_q * gdc_pkg::RCP5;
    rq_y    = by_q * gdc_pkg::RCP5;
    qx_s    = negx_q ? -$signed(RW'(rq_x >> gdc_pkg::RCP_SH))
                     : $signed(RW'(rq_x >> gdc_pkg::RCP_SH));
    qy_s    = negy_q ? -$signed(RW'(rq_y >> gdc_pkg::RCP_SH))
                     : $signed(RW'(rq_y >> gdc_pkg::RCP_SH));
    rx_neg  = rx_q[RW-1];
    ry_neg  = ry_q[RW-1];
    rx_zero = (rx_q == '0);
    ry_zero = (ry_q == '0);
    abs_rx  = rx_neg ? RW'(-rx_q) : RW'(rx_q);
    abs_ry  = ry_neg ? RW'(-ry_q) : RW'(ry_q);
    fsel_x  = rx_neg ? {1'b0, pos_x_q[15:0]} : 17'h10000 - {1'b0, pos_x_q[15:0]};
    fsel_y  = ry_neg ? {1'b0, pos_y_q[15:0]} : 17'h10000 - {1'b0, pos_y_q[15:0]};
    smul_x  = fsel_x * dx_q[32:0];
    smul_y  = fsel_y * dy_q[32:0];

    step_x  = sx_q < sy_q;
    cx_n    = cx_q;
    cy_n    = cy_q;
    if (step_x) begin
      cx_n = rx_neg ? cx_q - CW'(1) : cx_q + CW'(1);
    end else begin
      cy_n = ry_neg ? cy_q - CW'(1) : cy_q + CW'(1);
    end
    n_in    = gdc_pkg::in_map(cx_n, cy_n);
    dist_d  = side_q ? sy_q - SW'(dy_q) : sx_q - SW'(dx_q);

    nx = cx_q;
    ny = cy_q;
    if (!side_q) begin
      nx = rx_neg ? cx_q + CW'(1) : cx_q - CW'(1);
    end else begin
      ny = ry_neg ? cy_q + CW'(1) : cy_q - CW'(1);
    end

    half     = lh_q >> 1;
    half_big = half >= gdc_pkg::LH_W'(HALF_H);
    num_t    = gdc_pkg::NT_W'({1'b0, lh_q}) + gdc_pkg::NT_W'({start_q, 1'b0})
             - gdc_pkg::NT_W'(gdc_pkg::SCREEN_H);

    wsel  = side_q ? rx_q : ry_q;
    wop   = {{(32 - RW){wsel[RW-1]}}, wsel};
    wfull = dist_q[31:0] * wop;
    wfrac = (side_q ? pos_x_q[15:0] : pos_y_q[15:0]) + wprod_q[31:16];
    tmul  = 22'(wfrac) * 22'(gdc_pkg::TEX_W);
    mirror = side_q ? ry_neg : (!rx_neg && !rx_zero);
    tcol  = mirror ? 6'(gdc_pkg::TEX_W - 1) - tmul[21:16] : tmul[21:16];

    thalf    = tprod_q >> 1;
    tstart   = (lh_q == '0 || num_neg_q) ? 23'd0 :
               (thalf > gdc_pkg::TP_W'(gdc_pkg::SAT23)) ? gdc_pkg::SAT23 : thalf[22:0];
    step_sat = (lh_q == '0) ? gdc_pkg::SAT23 :
               (step_raw_q > gdc_pkg::STEPR_W'(gdc_pkg::SAT23)) ? gdc_pkg::SAT23
                                                              : step_raw_q[22:0];
    if (!side_q) begin
      face = rx_neg ? gdc_pkg::FACE_WEST : gdc_pkg::FACE_EAST;
    end else begin
      face = ry_neg ? gdc_pkg::FACE_NORTH : gdc_pkg::FACE_SOUTH;
    end
    vm1 = 7'(v_q - 8'sd1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gdc_pkg::S_IDLE: begin
        if (in_acc && in_i.kind == gdc_pkg::KIND_CAST) state_d = gdc_pkg::S_RAY_GO;
      end
      gdc_pkg::S_RAY_GO:    state_d = gdc_pkg::S_RAY_DIV;
      gdc_pkg::S_RAY_DIV:   state_d = gdc_pkg::S_DELTA_GO;
      gdc_pkg::S_DELTA_GO:  state_d = gdc_pkg::S_DELTA_DIV;
      gdc_pkg::S_DELTA_DIV: begin
        if (div_x_rsp.done) state_d = gdc_pkg::S_SIDE;
      end
      gdc_pkg::S_SIDE:      state_d = gdc_pkg::S_WALK;
      gdc_pkg::S_WALK:      state_d = n_in ? gdc_pkg::S_LOOK : gdc_pkg::S_FIN;
      gdc_pkg::S_LOOK: begin
        if (rd_data > 8'sd0) state_d = gdc_pkg::S_DIST;
        else if (walk_n_q == gdc_pkg::WALK_W'(gdc_pkg::WALK_MAX)) state_d = gdc_pkg::S_FIN;
        else state_d = gdc_pkg::S_WALK;
      end
      gdc_pkg::S_DIST:      state_d = (dist_d == '0) ? gdc_pkg::S_SPAN : gdc_pkg::S_LH_DIV;
      gdc_pkg::S_LH_DIV: begin
        if (div_x_rsp.done) state_d = gdc_pkg::S_SPAN;
      end
      gdc_pkg::S_SPAN:      state_d = (lh_q == '0) ? gdc_pkg::S_TEX : gdc_pkg::S_STEP_DIV;
      gdc_pkg::S_STEP_DIV: begin
        if (div_x_rsp.done) state_d = gdc_pkg::S_TEX;
      end
      gdc_pkg::S_TEX:       state_d = gdc_pkg::S_FIN;
      gdc_pkg::S_FIN: begin
        if (res_free) state_d = gdc_pkg::S_IDLE;
      end
      default:              state_d = gdc_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state_q == gdc_pkg::S_IDLE) && !clr_busy;
    div_x_req = '0;
    div_y_req = '0;
    wr_req    = '0;
    rd_req    = '0;
    case (state_q)
      gdc_pkg::S_IDLE: begin
        wr_req.en   = in_acc && in_i.kind == gdc_pkg::KIND_WRITE &&
                      gdc_pkg::in_map(CW'(in_i.cell_x), CW'(in_i.cell_y));
        wr_req.addr = gdc_pkg::cell_addr(CW'(in_i.cell_x), CW'(in_i.cell_y));
        wr_req.data = in_i.cell_value;
      end
      gdc_pkg::S_DELTA_GO: begin
        div_x_req.start    = 1'b1;
        div_x_req.dividend = gdc_pkg::NUM_W'(1) << 32;
        div_x_req.divisor  = gdc_pkg::DEN_W'(abs_rx);
        div_y_req.start    = 1'b1;
        div_y_req.dividend = gdc_pkg::NUM_W'(1) << 32;
        div_y_req.divisor  = gdc_pkg::DEN_W'(abs_ry);
      end
      gdc_pkg::S_WALK: begin
        rd_req.en   = n_in;
        rd_req.addr = gdc_pkg::cell_addr(cx_n, cy_n);
      end
      gdc_pkg::S_DIST: begin
        div_x_req.start    = (dist_d != '0);
        div_x_req.dividend = gdc_pkg::NUM_W'(gdc_pkg::SCREEN_H) << 16;
        div_x_req.divisor  = dist_d;
      end
      gdc_pkg::S_SPAN: begin
        div_x_req.start    = (lh_q != '0);
        div_x_req.dividend = gdc_pkg::NUM_W'(gdc_pkg::TEX_H) << 16;
        div_x_req.divisor  = gdc_pkg::DEN_W'(lh_q);
      end
      gdc_pkg::S_TEX: begin
        rd_req.en   = gdc_pkg::in_map(nx, ny);
        rd_req.addr = gdc_pkg::cell_addr(nx, ny);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      gdc_pkg::S_IDLE: begin
        col_q <= in_i.column;
        cam_q <= $signed({1'b0, in_i.column, 1'b0}) - gdc_pkg::CAM_W'(gdc_pkg::SCREEN_W);
        hit_q <= 1'b0;
      end
      gdc_pkg::S_RAY_GO: begin
        negx_q <= prod_x[gdc_pkg::PROD_W-1];
        negy_q <= prod_y[gdc_pkg::PROD_W-1];
        bx_q   <= gdc_pkg::RB_W'(abs_px >> gdc_pkg::RAY_PRE_SH);
        by_q   <= gdc_pkg::RB_W'(abs_py >> gdc_pkg::RAY_PRE_SH);
      end
      gdc_pkg::S_RAY_DIV: begin
        rx_q <= {{(RW - gdc_pkg::VEC_W){dir_x_q[gdc_pkg::VEC_W-1]}}, dir_x_q} + qx_s;
        ry_q <= {{(RW - gdc_pkg::VEC_W){dir_y_q[gdc_pkg::VEC_W-1]}}, dir_y_q} + qy_s;
      end
      gdc_pkg::S_DELTA_DIV: begin
        dx_q <= rx_zero ? gdc_pkg::DELTA_INF : gdc_pkg::DELTA_W'(div_x_rsp.quotient);
        dy_q <= ry_zero ? gdc_pkg::DELTA_INF : gdc_pkg::DELTA_W'(div_y_rsp.quotient);
      end
      gdc_pkg::S_SIDE: begin
        sx_q <= rx_zero ? SW'({fsel_x, 24'd0}) : SW'(smul_x >> 16);
        sy_q <= ry_zero ? SW'({fsel_y, 24'd0}) : SW'(smul_y >> 16);
        cx_q <= $signed(CW'(pos_x_q[gdc_pkg::POS_W-1:16]));
        cy_q <= $signed(CW'(pos_y_q[gdc_pkg::POS_W-1:16]));
        walk_n_q <= '0;
      end
      gdc_pkg::S_WALK: begin
        // advance along the axis whose next crossing is nearer; ties go to y
        if (step_x) begin
          sx_q   <= sx_q + SW'(dx_q);
          side_q <= 1'b0;
        end else begin
          sy_q   <= sy_q + SW'(dy_q);
          side_q <= 1'b1;
        end
        cx_q     <= cx_n;
        cy_q     <= cy_n;
        walk_n_q <= walk_n_q + gdc_pkg::WALK_W'(1);
      end
      gdc_pkg::S_LOOK: begin
        v_q <= rd_data;
        if (rd_data > 8'sd0) hit_q <= 1'b1;
      end
      gdc_pkg::S_DIST: begin
        dist_q <= dist_d;
        lh_q   <= gdc_pkg::LH_MAX;
      end
      gdc_pkg::S_LH_DIV: begin
        lh_q <= div_x_rsp.quotient[gdc_pkg::LH_W-1:0];
      end
      gdc_pkg::S_SPAN: begin
        start_q <= half_big ? 8'd0 : 8'(gdc_pkg::LH_W'(HALF_H) - half);
        end_q   <= half_big ? 8'(gdc_pkg::SCREEN_H) : 8'(half + gdc_pkg::LH_W'(HALF_H));
      end
      gdc_pkg::S_STEP_DIV: begin
        step_raw_q <= div_x_rsp.quotient[gdc_pkg::STEPR_W-1:0];
      end
      gdc_pkg::S_TEX: begin
        num_neg_q <= num_t[gdc_pkg::NT_W-1];
        tprod_q   <= num_t[gdc_pkg::NT_W-2:0] * step_raw_q;
        wprod_q   <= wfull[31:0];
        nb_in_q   <= gdc_pkg::in_map(nx, ny);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (state_q == gdc_pkg::S_FIN && res_free) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == gdc_pkg::S_FIN && res_free) begin
      res_col_q    <= col_q;
      res_hit_q    <= hit_q;
      res_side_q   <= hit_q && side_q;
      res_face_q   <= hit_q ? face : 2'd0;
      res_start_q  <= hit_q ? start_q : 8'd0;
      res_end_q    <= hit_q ? end_q : 8'd0;
      res_tex_q    <= hit_q ? vm1 : 7'd0;
      res_tcol_q   <= hit_q ? tcol : 6'd0;
      res_step_q   <= hit_q ? step_sat : 23'd0;
      res_tstart_q <= hit_q ? tstart : 23'd0;
      res_shade_q  <= hit_q && nb_in_q && rd_data[7];
      res_dist_q   <= !hit_q ? 24'd0 :
                      (dist_q > SW'(gdc_pkg::SAT24)) ? gdc_pkg::SAT24 : dist_q[23:0];
    end
  end

  assign in_i.ready          = in_ready;
  assign res_o.valid         = res_valid_q;
  assign res_o.out_column    = res_col_q;
  assign res_o.wall_hit      = res_hit_q;
  assign res_o.hit_side      = res_side_q;
  assign res_o.hit_face      = res_face_q;
  assign res_o.span_start    = res_start_q;
  assign res_o.span_end      = res_end_q;
  assign res_o.wall_texture  = res_tex_q;
  assign res_o.tex_column    = res_tcol_q;
  assign res_o.tex_row_step  = res_step_q;
  assign res_o.tex_row_start = res_tstart_q;
  assign res_o.shade         = res_shade_q;
  assign res_o.wall_distance = res_dist_q;

  `GDC_ASSERT(a_res_from_fin, $rose(res_valid_q) |-> $past(state_q) == gdc_pkg::S_FIN, "result beat not from finish")
  `GDC_ASSERT(a_div_start_idle, div_x_req.start |-> !div_x_rsp.busy, "divider restarted while busy")
  `GDC_ASSERT(a_cast_starts, (in_acc && in_i.kind == gdc_pkg::KIND_CAST) |=> state_q == gdc_pkg::S_RAY_GO, "cast beat did not start a ray")
  `GDC_ASSERT_CR(a_no_read_in_clear, clk_i, rst_ni, rd_req.en |-> !clr_busy, "map read during clear sweep")
endmodule
